>>> hw/rtl/ffw_pkg.sv
// Shared types and constants of the frame filter and forwarder.
// Used by ffw_out_seq and frame_filter_and_forwarder; depends on nothing.
package ffw_pkg;

    // Bytes at or past this position of a frame are not forwarded.
    localparam int FORWARD_LIMIT = 100;
    // Header bytes 0 to 14 are held; byte 14 triggers the verdict.
    localparam int HDR_LEN       = 15;
    localparam int HDR_IDX_W     = $clog2(HDR_LEN);
    localparam int POS_W         = $clog2(FORWARD_LIMIT + 1);

    // Result queue between the filter and the output register.
    localparam int Q_DEPTH       = 16;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam int CNT_W         = 16;
    localparam int TDATA_W       = 48;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_OWN_A   = 3'd0,
        CFG_OWN_B   = 3'd1,
        CFG_TYPE    = 3'd2,
        CFG_TADDR_0 = 3'd3,
        CFG_TADDR_1 = 3'd4,
        CFG_TNET_0  = 3'd5,
        CFG_TNET_1  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        V_SAME_NET    = 3'd0,
        V_SENT        = 3'd1,
        V_FILTERED    = 3'd2,
        V_UNKNOWN_SRC = 3'd3,
        V_BAD_NET     = 3'd4,
        V_NO_PORT     = 3'd5
    } t_verdict;

    // Header bytes, entry i is frame byte i.
    typedef logic [HDR_LEN-1:0][7:0] t_snap;

    // One queue entry: a single result, or (burst set) a verdict that is
    // followed by the header bytes of the snapshot.
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        logic              port;
        logic              last;
        t_verdict          verdict;
        logic [CNT_W-1:0]  recv_cnt;
        logic [CNT_W-1:0]  drop_cnt;
        logic              burst;
        logic              hdr_last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic snap_busy;
    } t_seq_status;

endpackage

>>> hw/rtl/ffw_out_seq.sv
// Result queue, header burst sequencer and output register.
// Depends on ffw_pkg.
module ffw_out_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ffw_pkg::t_entry        i_push_entry,
    input  logic                   i_snap_we,
    input  ffw_pkg::t_snap         i_snap,
    output ffw_pkg::t_seq_status   o_status,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata, low bit up: out_byte[7:0], out_port[8], verdict[11:9],
    // received_count[27:12], dropped_count[43:28], zero[47:44]
    output logic [ffw_pkg::TDATA_W-1:0] m_axis_tdata,
    // tuser: item_kind
    output logic                   m_axis_tuser,
    // tlast: out_last
    output logic                   m_axis_tlast
);
    import ffw_pkg::*;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_LEN - 1);
    localparam int PAD_W = TDATA_W - 8 - 1 - 3 - 2 * CNT_W;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        logic              port;
        logic              last;
        t_verdict          verdict;
        logic [CNT_W-1:0]  recv_cnt;
        logic [CNT_W-1:0]  drop_cnt;
    } t_result;

    t_entry                r_q [Q_DEPTH];
    logic [Q_AW-1:0]       r_wr;
    logic [Q_AW-1:0]       r_rd;
    logic [Q_AW:0]         r_cnt;
    t_snap                 r_snap;
    logic                  r_snap_busy;
    logic                  r_seq_hdr;
    logic [HDR_IDX_W-1:0]  r_hidx;
    logic                  r_out_valid;
    t_result               r_out;

    t_entry                w_head;
    logic                  w_empty;
    logic                  w_load;
    logic                  w_take;
    logic                  w_pop;
    t_result               n_out;

    assign w_head  = r_q[r_rd];
    assign w_empty = (r_cnt == '0);
    assign w_load  = !r_out_valid || m_axis_tready;
    assign w_take  = w_load && !w_empty;

    always_comb begin
        w_pop = 1'b0;
        n_out = '{kind: w_head.kind, data: w_head.data, port: w_head.port,
                  last: w_head.last, verdict: w_head.verdict,
                  recv_cnt: w_head.recv_cnt, drop_cnt: w_head.drop_cnt};
        if (w_head.burst && r_seq_hdr) begin
            // header byte of a sent frame
            n_out.kind    = KIND_BYTE;
            n_out.data    = r_snap[r_hidx];
            n_out.last    = w_head.hdr_last && (r_hidx == HDR_LAST);
            n_out.verdict = V_SAME_NET;
        end
        if (w_take) begin
            w_pop = !w_head.burst || (r_seq_hdr && (r_hidx == HDR_LAST));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_cnt       <= '0;
            r_snap_busy <= 1'b0;
            r_seq_hdr   <= 1'b0;
            r_hidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
            if (w_load) begin
                r_out_valid <= !w_empty;
            end
            if (w_take && w_head.burst) begin
                if (!r_seq_hdr) begin
                    r_seq_hdr <= 1'b1;
                    r_hidx    <= '0;
                end else if (r_hidx == HDR_LAST) begin
                    r_seq_hdr <= 1'b0;
                end else begin
                    r_hidx <= r_hidx + 1'b1;
                end
            end
            if (w_pop && w_head.burst) begin
                r_snap_busy <= 1'b0;
            end
            if (i_snap_we) begin
                r_snap_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_push_entry;
        end
        if (i_snap_we) begin
            r_snap <= i_snap;
        end
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_status.full      = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_status.snap_busy = r_snap_busy;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out.drop_cnt, r_out.recv_cnt,
                            r_out.verdict, r_out.port, r_out.data};

endmodule

>>> hw/rtl/frame_filter_and_forwarder.sv
// Frame filter and forwarder: top level with filter, router and config.
// Depends on ffw_pkg and ffw_out_seq.
// Path of an item: input register, result queue, output register.
// Throughput: one item a cycle; input stalls only when the 16-entry result queue is full
// or byte 14 of a frame meets the unsent 15-byte header burst of an earlier frame.
// Reset: synchronous, active low; clears counts and position, reloads defaults.
module frame_filter_and_forwarder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // frame in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: frame_byte[7:0]
    input  logic [7:0]  s_axis_tdata,
    // tlast: frame_end
    input  logic        s_axis_tlast,
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: out_byte[7:0], out_port[8], verdict[11:9],
    // received_count[27:12], dropped_count[43:28], zero[47:44]
    output logic [ffw_pkg::TDATA_W-1:0] m_axis_tdata,
    // tuser: item_kind
    output logic        m_axis_tuser,
    // tlast: out_last
    output logic        m_axis_tlast
);
    import ffw_pkg::*;

    localparam logic [POS_W-1:0] POS_JUDGE = POS_W'(HDR_LEN - 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FORWARD_LIMIT);
    localparam logic [POS_W-1:0] POS_FINAL = POS_W'(FORWARD_LIMIT - 1);
    localparam logic             HDR_ENDS  = (FORWARD_LIMIT <= HDR_LEN);

    // Configuration registers
    logic [47:0]      r_own_a;
    logic [47:0]      r_own_b;
    logic [15:0]      r_ftype;
    logic [47:0]      r_taddr_0;
    logic [47:0]      r_taddr_1;
    logic [7:0]       r_tnet_0;
    logic [7:0]       r_tnet_1;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_end;

    // Frame state
    t_snap            r_hdr;
    logic [POS_W-1:0] r_pos;
    logic             r_fa;
    logic             r_eport;
    logic [CNT_W-1:0] r_passed;
    logic [CNT_W-1:0] r_rejected;

    logic [POS_W-1:0] n_pos;
    logic             n_fa;
    logic             n_eport;
    logic [CNT_W-1:0] n_passed;
    logic [CNT_W-1:0] n_rejected;

    t_seq_status      w_status;
    logic             w_proceed;
    logic             w_push;
    t_entry           w_entry;
    logic             w_snap_we;
    t_snap            w_snap;

    // Verdict logic, all on the held header and the byte in the input register
    logic [47:0]      w_dst;
    logic [47:0]      w_src;
    logic [15:0]      w_type;
    logic             w_pass;
    logic [7:0]       w_net;
    logic [47:0]      w_newdst;
    logic             w_port;
    t_verdict         w_verdict;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_a   <= '0;
            r_own_b   <= '0;
            r_ftype   <= 16'habcd;
            r_taddr_0 <= 48'h0800_272e_1175;
            r_taddr_1 <= 48'h0800_2700_2bb3;
            r_tnet_0  <= 8'd1;
            r_tnet_1  <= 8'd2;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OWN_A:   r_own_a   <= i_cfg_data;
                CFG_OWN_B:   r_own_b   <= i_cfg_data;
                CFG_TYPE:    r_ftype   <= i_cfg_data[15:0];
                CFG_TADDR_0: r_taddr_0 <= i_cfg_data;
                CFG_TADDR_1: r_taddr_1 <= i_cfg_data;
                CFG_TNET_0:  r_tnet_0  <= i_cfg_data[7:0];
                CFG_TNET_1:  r_tnet_1  <= i_cfg_data[7:0];
                default:     r_own_a   <= r_own_a;
            endcase
        end
    end

    // Hold the item while the queue is full, or while byte 14 would need the
    // snapshot that an earlier header burst still occupies.
    assign w_proceed = r_in_valid && !w_status.full
                       && !((r_pos == POS_JUDGE) && w_status.snap_busy);
    assign s_axis_tready = !r_in_valid || w_proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    // Destination and source go byte 0 first, most significant.
    assign w_dst  = {r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3], r_hdr[4], r_hdr[5]};
    assign w_src  = {r_hdr[6], r_hdr[7], r_hdr[8], r_hdr[9], r_hdr[10], r_hdr[11]};
    assign w_type = {r_hdr[12], r_hdr[13]};

    always_comb begin
        w_pass    = ((w_dst == r_own_a) || (w_dst == r_own_b)) && (w_type == r_ftype);
        w_net     = r_tnet_0;
        w_newdst  = r_taddr_0;
        w_port    = 1'b0;
        w_verdict = V_SENT;
        if (!w_pass) begin
            w_verdict = V_FILTERED;
        end else begin
            // unknown source wins over the network check
            if (w_src == r_taddr_0) begin
                w_net = r_tnet_0;
            end else if (w_src == r_taddr_1) begin
                w_net = r_tnet_1;
            end else begin
                w_verdict = V_UNKNOWN_SRC;
            end
            if (w_verdict == V_SENT) begin
                if (w_net == r_in_byte) begin
                    w_verdict = V_SAME_NET;
                end else if (r_in_byte == 8'd1) begin
                    w_newdst = r_taddr_0;
                end else if (r_in_byte == 8'd2) begin
                    w_newdst = r_taddr_1;
                end else begin
                    w_verdict = V_BAD_NET;
                end
            end
            if (w_verdict == V_SENT) begin
                if (w_net == 8'd1) begin
                    w_port = 1'b0;
                end else if (w_net == 8'd2) begin
                    w_port = 1'b1;
                end else begin
                    w_verdict = V_NO_PORT;
                end
            end
        end
    end

    // Header snapshot with the destination rewritten, for the burst.
    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            if (i < 6) begin
                w_snap[i] = w_newdst[8 * (5 - i) +: 8];
            end else if (i < HDR_LEN - 1) begin
                w_snap[i] = r_hdr[i];
            end else begin
                w_snap[i] = r_in_byte;
            end
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_fa       = r_fa;
        n_eport    = r_eport;
        n_passed   = r_passed;
        n_rejected = r_rejected;
        w_push     = 1'b0;
        w_snap_we  = 1'b0;
        w_entry    = '0;
        if (w_proceed) begin
            if (r_pos < POS_JUDGE) begin
                // short frame: drop
                if (r_in_end) begin
                    n_rejected      = r_rejected + 1'b1;
                    w_push          = 1'b1;
                    w_entry.kind    = KIND_VERDICT;
                    w_entry.verdict = V_FILTERED;
                end
            end else if (r_pos == POS_JUDGE) begin
                if (w_pass) begin
                    n_passed = r_passed + 1'b1;
                end else begin
                    n_rejected = r_rejected + 1'b1;
                end
                w_push           = 1'b1;
                w_entry.kind     = KIND_VERDICT;
                w_entry.verdict  = w_verdict;
                w_entry.hdr_last = r_in_end || HDR_ENDS;
                if (w_verdict == V_SENT) begin
                    w_entry.port  = w_port;
                    w_entry.burst = 1'b1;
                    w_snap_we     = 1'b1;
                    n_eport       = w_port;
                    n_fa          = !(r_in_end || HDR_ENDS);
                end
            end else if (r_fa && (r_pos < POS_LIMIT)) begin
                w_push       = 1'b1;
                w_entry.kind = KIND_BYTE;
                w_entry.data = r_in_byte;
                w_entry.port = r_eport;
                w_entry.last = r_in_end || (r_pos == POS_FINAL);
                if (w_entry.last) begin
                    n_fa = 1'b0;
                end
            end
            w_entry.recv_cnt = n_passed;
            w_entry.drop_cnt = n_rejected;
            // advance position, saturate at the forward limit
            if (r_in_end) begin
                n_pos = '0;
                n_fa  = 1'b0;
            end else if (r_pos < POS_LIMIT) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_fa       <= 1'b0;
            r_eport    <= 1'b0;
            r_passed   <= '0;
            r_rejected <= '0;
        end else begin
            r_pos      <= n_pos;
            r_fa       <= n_fa;
            r_eport    <= n_eport;
            r_passed   <= n_passed;
            r_rejected <= n_rejected;
        end
    end

    // Header store: bytes 0 to 14 of the current frame.
    always_ff @(posedge i_clk) begin
        if (w_proceed && (r_pos <= POS_JUDGE)) begin
            r_hdr[r_pos[HDR_IDX_W-1:0]] <= r_in_byte;
        end
    end

    ffw_out_seq u_out_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_push_entry  (w_entry),
        .i_snap_we     (w_snap_we),
        .i_snap        (w_snap),
        .o_status      (w_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Forwarding only runs once the header has been judged.
    a_fwd_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fa |-> (r_pos > POS_JUDGE))
        else $error("forwarding active inside the header");

    // Never overwrite a snapshot whose burst is still queued.
    a_snap_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_we |-> !w_status.snap_busy)
        else $error("header snapshot overwritten while busy");

    // Never push into a full result queue.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_status.full)
        else $error("result queue overflow");

    // A verdict item never closes a forwarded frame.
    a_verdict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_VERDICT)) |-> !m_axis_tlast)
        else $error("verdict item marked last");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for frame_filter_and_forwarder: drives frames, predicts every result.
// Depends on ffw_pkg and the frame_filter_and_forwarder RTL.
`timescale 1ns / 100ps

module testbench;
    import ffw_pkg::*;

    // Cycles to let pass once nothing is expected: latency plus margin.
    localparam int DRAIN_CYCLES = 12;
    // Length of the long receiver hold-off.
    localparam int RECV_HOLD    = 250;
    // Minimum input items per random phase.
    localparam int RANDOM_ITEMS = 12;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = CFG_OWN_A;
    logic [47:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // One result as the block should present it.
    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        logic        port;
        logic        last;
        t_verdict    verdict;
        logic [15:0] recv;
        logic [15:0] drop;
    } t_egress_item;

    t_egress_item pending_results[$];

    // Predictor copy of the configuration, reset values included.
    logic [47:0] cfg_own_a     = 48'h0;
    logic [47:0] cfg_own_b     = 48'h0;
    logic [15:0] cfg_type      = 16'hABCD;
    logic [47:0] cfg_tab_addr0 = 48'h0800_272E_1175;
    logic [47:0] cfg_tab_addr1 = 48'h0800_2700_2BB3;
    logic [7:0]  cfg_tab_net0  = 8'd1;
    logic [7:0]  cfg_tab_net1  = 8'd2;

    // Predictor copy of the frame state.
    logic [7:0]  hdr_copy [HDR_LEN];
    int          frame_pos     = 0;
    logic        fwd_active    = 1'b0;
    logic        fwd_port      = 1'b0;
    logic [15:0] passed_cnt    = '0;
    logic [15:0] rejected_cnt  = '0;

    int send_idle_pct = 21;
    int recv_idle_pct = 84;
    int items_sent    = 0;
    int errors        = 0;
    int hold_orders   = 0;
    int hold_taken    = 0;
    int hold_left     = 0;

    frame_filter_and_forwarder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void push_result(input t_kind kind, input logic [7:0] data,
                                        input logic port, input logic last,
                                        input t_verdict verdict);
        t_egress_item r;
        r.kind    = kind;
        r.data    = data;
        r.port    = port;
        r.last    = last;
        r.verdict = verdict;
        r.recv    = passed_cnt;
        r.drop    = rejected_cnt;
        pending_results.push_back(r);
    endfunction

    // Decide the fate of a complete header; rewrite the destination when routed.
    function automatic t_verdict judge_header();
        logic [47:0] dst;
        logic [47:0] src;
        logic [47:0] new_dst;
        logic [15:0] typ;
        logic [7:0]  target;
        logic [7:0]  net;
        dst    = {hdr_copy[0], hdr_copy[1], hdr_copy[2], hdr_copy[3], hdr_copy[4], hdr_copy[5]};
        src    = {hdr_copy[6], hdr_copy[7], hdr_copy[8], hdr_copy[9], hdr_copy[10],
                  hdr_copy[11]};
        typ    = {hdr_copy[12], hdr_copy[13]};
        target = hdr_copy[14];

        if ((dst != cfg_own_a && dst != cfg_own_b) || typ != cfg_type) begin
            rejected_cnt++;
            return V_FILTERED;
        end
        passed_cnt++;

        // Unknown source still counts as passed.
        if (src == cfg_tab_addr0)
            net = cfg_tab_net0;
        else if (src == cfg_tab_addr1)
            net = cfg_tab_net1;
        else
            return V_UNKNOWN_SRC;

        if (net == target)
            return V_SAME_NET;
        if (target == 8'd1)
            new_dst = cfg_tab_addr0;
        else if (target == 8'd2)
            new_dst = cfg_tab_addr1;
        else
            return V_BAD_NET;

        for (int i = 0; i < 6; i++)
            hdr_copy[i] = new_dst[47 - 8*i -: 8];

        if (net == 8'd1)
            fwd_port = 1'b0;
        else if (net == 8'd2)
            fwd_port = 1'b1;
        else
            return V_NO_PORT;
        fwd_active = 1'b1;
        return V_SENT;
    endfunction

    // Advance the predictor by one accepted frame byte and queue what it yields.
    function automatic void filter_step(input logic [7:0] b, input logic fin);
        int       pos;
        t_verdict v;
        logic     lst;
        pos = frame_pos;
        if (pos < HDR_LEN)
            hdr_copy[pos] = b;

        if (pos < HDR_LEN - 1) begin
            // Short frame: verdict filtered, nothing forwarded.
            if (fin) begin
                rejected_cnt++;
                push_result(KIND_VERDICT, 8'h00, 1'b0, 1'b0, V_FILTERED);
            end
        end else if (pos == HDR_LEN - 1) begin
            v = judge_header();
            push_result(KIND_VERDICT, 8'h00, (v == V_SENT) ? fwd_port : 1'b0, 1'b0, v);
            if (v == V_SENT) begin
                lst = fin || (FORWARD_LIMIT <= HDR_LEN);
                for (int i = 0; i < HDR_LEN; i++)
                    push_result(KIND_BYTE, hdr_copy[i], fwd_port,
                                (i == HDR_LEN - 1) && lst, V_SAME_NET);
                if (lst)
                    fwd_active = 1'b0;
            end
        end else if (fwd_active && pos < FORWARD_LIMIT) begin
            lst = fin || (pos == FORWARD_LIMIT - 1);
            push_result(KIND_BYTE, b, fwd_port, lst, V_SAME_NET);
            if (lst)
                fwd_active = 1'b0;
        end

        if (fin) begin
            frame_pos  = 0;
            fwd_active = 1'b0;
        end else if (pos < FORWARD_LIMIT) begin
            frame_pos = pos + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random or for a long stretch on order, and check
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_orders != hold_taken) begin
            hold_taken = hold_orders;
            hold_left  = RECV_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_egress_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: tdata 0x%0h tuser %0b tlast %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("item_kind",      want.kind,    m_axis_tuser);
                check_field("out_byte",       want.data,    m_axis_tdata[7:0]);
                check_field("out_port",       want.port,    m_axis_tdata[8]);
                check_field("out_last",       want.last,    m_axis_tlast);
                check_field("verdict",        want.verdict, m_axis_tdata[11:9]);
                check_field("received_count", want.recv,    m_axis_tdata[27:12]);
                check_field("dropped_count",  want.drop,    m_axis_tdata[43:28]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame side and configuration
    // ------------------------------------------------------------------

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Offer one item; valid stays high after acceptance so that back-to-back
    // items never lower and raise it in one step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        filter_step(b, fin);
        items_sent++;
    endtask

    // Build a frame from header fields; bytes past the header are random.
    task automatic send_frame(input logic [47:0] dst, input logic [47:0] src,
                              input logic [15:0] typ, input logic [7:0] target,
                              input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (i < 6)
                b = dst[47 - 8*i -: 8];
            else if (i < 12)
                b = src[47 - 8*(i-6) -: 8];
            else if (i == 12)
                b = typ[15:8];
            else if (i == 13)
                b = typ[7:0];
            else if (i == 14)
                b = target;
            else
                b = 8'($urandom);
            send_byte(b, i == len - 1);
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipe empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_OWN_A:   cfg_own_a     = val;
            CFG_OWN_B:   cfg_own_b     = val;
            CFG_TYPE:    cfg_type      = val[15:0];
            CFG_TADDR_0: cfg_tab_addr0 = val;
            CFG_TADDR_1: cfg_tab_addr1 = val;
            CFG_TNET_0:  cfg_tab_net0  = val[7:0];
            CFG_TNET_1:  cfg_tab_net1  = val[7:0];
            default: ;
        endcase
    endtask

    // Rewrite every register while the block is idle.
    task automatic set_config(input logic [47:0] own_a, input logic [47:0] own_b,
                              input logic [15:0] typ, input logic [47:0] ta0,
                              input logic [47:0] ta1, input logic [7:0] tn0,
                              input logic [7:0] tn1);
        settle();
        write_reg(CFG_OWN_A,   own_a);
        write_reg(CFG_OWN_B,   own_b);
        write_reg(CFG_TYPE,    {32'h0, typ});
        write_reg(CFG_TADDR_0, ta0);
        write_reg(CFG_TADDR_1, ta1);
        write_reg(CFG_TNET_0,  {40'h0, tn0});
        write_reg(CFG_TNET_1,  {40'h0, tn1});
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content; some noise and odd lengths.
    task automatic send_random_frame();
        logic [47:0] dst;
        logic [47:0] src;
        logic [15:0] typ;
        logic [7:0]  target;
        int          len;
        int          pick;
        pick   = $urandom_range(9);
        dst    = (pick < 4) ? cfg_own_a : (pick < 8) ? cfg_own_b : rand48();
        typ    = ($urandom_range(9) < 8) ? cfg_type : 16'($urandom);
        pick   = $urandom_range(9);
        src    = (pick < 4) ? cfg_tab_addr0 : (pick < 8) ? cfg_tab_addr1 : rand48();
        pick   = $urandom_range(9);
        target = (pick < 4) ? 8'd1 : (pick < 8) ? 8'd2 : 8'($urandom);
        pick   = $urandom_range(99);
        if (pick < 10)
            len = $urandom_range(14, 1);
        else if (pick < 16)
            len = $urandom_range(130, 95);
        else
            len = $urandom_range(40, 15);
        send_frame(dst, src, typ, target, len);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values alone: own addresses zero, default type and table.
    task automatic test_reset_defaults();
        send_frame(48'h0, cfg_tab_addr0, cfg_type, 8'd2, 20);
        send_frame(48'h0, cfg_tab_addr1, cfg_type, 8'd1, 16);
    endtask

    // Filter and every routing verdict but no port under an ordinary setting.
    task automatic test_verdicts();
        set_config(48'h02AA_BB00_0001, 48'h02AA_BB00_0002, 16'h88B5,
                   48'h0A0B_0C0D_0E0F, 48'h1A1B_1C1D_1E1F, 8'd1, 8'd2);
        send_frame(48'h02AA_BB00_0003, cfg_tab_addr0, cfg_type, 8'd2, 15);  // wrong dest
        send_frame(cfg_own_b, cfg_tab_addr0, cfg_type ^ 16'h0100, 8'd2, 15); // wrong type
        send_frame(cfg_own_a, 48'h0A0B_0C0D_0E10, cfg_type, 8'd2, 16);      // unknown source
        send_frame(cfg_own_a, cfg_tab_addr0, cfg_type, 8'd1, 16);           // same network
        send_frame(cfg_own_b, cfg_tab_addr1, cfg_type, 8'd0, 16);           // bad target
        send_frame(cfg_own_b, cfg_tab_addr1, cfg_type, 8'd3, 16);
        send_frame(cfg_own_a, cfg_tab_addr0, cfg_type, 8'd2, 17);           // sent, port 0
        send_frame(cfg_own_b, cfg_tab_addr1, cfg_type, 8'd1, 15);           // sent, port 1
    endtask

    // Short, limit-edge and long frames.
    task automatic test_frame_lengths();
        send_frame(cfg_own_a, cfg_tab_addr0, cfg_type, 8'd2, 1);
        send_frame(cfg_own_a, cfg_tab_addr0, cfg_type, 8'd2, 14);
        send_frame(cfg_own_b, cfg_tab_addr0, cfg_type, 8'd2, 101);
    endtask

    // Extreme register values: all-ones and zero addresses, odd networks.
    task automatic test_extreme_config();
        set_config(48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                   48'hFFFF_FFFF_FFFF, 48'h0, 8'd255, 8'd0);
        send_frame(cfg_own_b, cfg_tab_addr0, cfg_type, 8'd1, 15);   // routed without port
        send_frame(cfg_own_b, cfg_tab_addr0, cfg_type, 8'd255, 15); // same network
        send_frame(cfg_own_a, cfg_tab_addr0, cfg_type, 8'd0, 15);   // bad target
        send_frame(cfg_own_a, cfg_tab_addr1, cfg_type, 8'd0, 15);   // same network
        send_frame(cfg_own_a, cfg_tab_addr1, cfg_type, 8'd2, 15);   // routed without port
        set_config(48'hFFFF_FFFF_FFFF, 48'h0, 16'h0000,
                   48'h0, 48'hFFFF_FFFF_FFFF, 8'd2, 8'd1);
        send_frame(cfg_own_a, cfg_tab_addr0, cfg_type, 8'd1, 17);   // swapped: port 1
        send_frame(cfg_own_b, cfg_tab_addr1, cfg_type, 8'd2, 17);   // swapped: port 0
    endtask

    // Hold the receiver off while frames keep coming, then pause until drained.
    task automatic test_backpressure();
        set_config(48'h0200_0000_00A1, 48'h0200_0000_00A2, 16'h0800,
                   48'h0200_0000_0B01, 48'h0200_0000_0B02, 8'd1, 8'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_orders++;
        // each frame queues more entries than the result queue holds
        send_frame(cfg_own_b, cfg_tab_addr0, cfg_type, 8'd2, 32);
        send_frame(cfg_own_a, cfg_tab_addr1, cfg_type, 8'd1, 32);
        settle();
        send_frame(cfg_own_a, cfg_tab_addr0, cfg_type, 8'd2, 16);
    endtask

    task automatic test_random(input int send_pct, input int recv_pct);
        int goal;
        logic [7:0] tn0;
        logic [7:0] tn1;
        tn0 = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2, 1));
        tn1 = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2, 1));
        set_config(rand48(), rand48(), 16'($urandom), rand48(), rand48(), tn0, tn1);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
            send_random_frame();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_verdicts();
        test_frame_lengths();
        test_extreme_config();
        test_random(21, 84);
        test_random(84, 21);
        test_random(0, 0);
        test_backpressure();

        settle();
        if (errors == 0)
            $display("** frame_filter_and_forwarder: PASSED **");
        else
            $display("** frame_filter_and_forwarder: FAILED **");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("** frame_filter_and_forwarder: FAILED **");
        $finish;
    end

endmodule
